// ----- sv/ailp_pkg.sv -----
`default_nettype none

package ailp_pkg;

  // Field width and derived limits
  localparam int VALUE_BITS = 16;
  localparam int MAG_W      = VALUE_BITS + 1;
  localparam int PROD_W     = MAG_W + 4;

  localparam logic [MAG_W-1:0] HALF_RANGE = MAG_W'(1) << (VALUE_BITS - 1);
  localparam logic [MAG_W-1:0] MAG_CAP    = HALF_RANGE + MAG_W'(1);
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Character codes
  localparam logic [7:0] CH_GYRO  = 8'h47;
  localparam logic [7:0] CH_ACC   = 8'h41;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field index codes
  localparam logic [1:0] FI_X   = 2'd0;
  localparam logic [1:0] FI_Y   = 2'd1;
  localparam logic [1:0] FI_Z   = 2'd2;
  localparam logic [1:0] FI_CHK = 2'd3;

  // Frame kind codes on the result port
  localparam logic FK_GYRO = 1'b0;
  localparam logic FK_ACC  = 1'b1;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0,
    LK_GYRO = 2'd1,
    LK_ACC  = 2'd2
  } line_kind_t;

  typedef enum logic [1:0] {
    NP_PRE    = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_DONE   = 2'd3
  } num_phase_t;

  // Byte class produced by the front end
  typedef struct packed {
    logic       nl;
    logic       gyro;
    logic       acc;
    logic       space;
    logic       ws;
    logic       plus;
    logic       minus;
    logic       digit;
    logic [3:0] dval;
  } byte_cls_t;

  typedef struct packed {
    logic                  frame_kind;
    logic [VALUE_BITS-1:0] axis_x;
    logic [VALUE_BITS-1:0] axis_y;
    logic [VALUE_BITS-1:0] axis_z;
    logic                  clipped;
  } result_t;

  typedef struct packed {
    logic                  clip;
    logic [VALUE_BITS-1:0] value;
  } sat_t;

  // Saturate a sign/magnitude field to the two's complement range
  function automatic sat_t sat_value(input logic [MAG_W-1:0] mag, input logic neg);
    sat_t             r;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] m_neg;
    if (neg) begin
      r.clip  = (mag > HALF_RANGE);
      m       = r.clip ? HALF_RANGE : mag;
      m_neg   = MAG_W'(0) - m;
      r.value = m_neg[VALUE_BITS-1:0];
    end else begin
      r.clip  = (mag > (HALF_RANGE - MAG_W'(1)));
      r.value = r.clip ? VAL_MAX : mag[VALUE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ailp_front.sv -----
`default_nettype none

module ailp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [7:0]          rx_byte,
  output      logic                full,
  output      logic                cls_valid,
  output      ailp_pkg::byte_cls_t cls,
  input  wire logic                cls_take
);

  ailp_pkg::byte_cls_t cls_in;
  ailp_pkg::byte_cls_t q_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                do_push, do_pop;
  logic [7:0]          dsub;

  // Classify the incoming word
  always_comb begin
    dsub         = rx_byte - ailp_pkg::CH_ZERO;
    cls_in.nl    = (rx_byte == ailp_pkg::CH_NL);
    cls_in.gyro  = (rx_byte == ailp_pkg::CH_GYRO);
    cls_in.acc   = (rx_byte == ailp_pkg::CH_ACC);
    cls_in.space = (rx_byte == ailp_pkg::CH_SPACE);
    cls_in.ws    = (rx_byte == ailp_pkg::CH_TAB) || (rx_byte == ailp_pkg::CH_VT) ||
                   (rx_byte == ailp_pkg::CH_FF)  || (rx_byte == ailp_pkg::CH_CR);
    cls_in.plus  = (rx_byte == ailp_pkg::CH_PLUS);
    cls_in.minus = (rx_byte == ailp_pkg::CH_MINUS);
    cls_in.digit = (rx_byte >= ailp_pkg::CH_ZERO) && (rx_byte <= ailp_pkg::CH_NINE);
    cls_in.dval  = dsub[3:0];
  end

  // Two-entry queue toward the back end
  assign full      = (cnt_r == 2'd2);
  assign cls_valid = (cnt_r != 2'd0);
  assign cls       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cls_take && cls_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ailp_back.sv -----
`default_nettype none

module ailp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cls_valid,
  input  wire ailp_pkg::byte_cls_t cls,
  output      logic                cls_take,
  input  wire logic                res_full,
  output      logic                res_push,
  output      ailp_pkg::result_t   res
);

  logic                             line_start_r, line_start_nxt;
  ailp_pkg::line_kind_t             kind_r, kind_nxt;
  logic [1:0]                       fidx_r, fidx_nxt;
  logic [ailp_pkg::MAG_W-1:0]       mag_r, mag_nxt;
  logic                             neg_r, neg_nxt;
  ailp_pkg::num_phase_t             phase_r, phase_nxt;
  logic [ailp_pkg::VALUE_BITS-1:0]  held0_r, held0_nxt;
  logic [ailp_pkg::VALUE_BITS-1:0]  held1_r, held1_nxt;
  logic                             clip_seen_r, clip_seen_nxt;

  logic                             go;
  ailp_pkg::sat_t                   fv;
  logic [ailp_pkg::PROD_W-1:0]      mag_ext;
  logic [ailp_pkg::PROD_W-1:0]      mag_dec;

  assign go       = cls_valid && !res_full;
  assign cls_take = go;
  assign fv       = ailp_pkg::sat_value(mag_r, neg_r);

  // Accumulate one decimal digit
  always_comb begin
    mag_ext = ailp_pkg::PROD_W'(mag_r);
    mag_dec = (mag_ext << 3) + (mag_ext << 1) + ailp_pkg::PROD_W'(cls.dval);
  end

  // Parse one word per cycle while a word waits and the result queue has room
  always_comb begin
    line_start_nxt = line_start_r;
    kind_nxt       = kind_r;
    fidx_nxt       = fidx_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    phase_nxt      = phase_r;
    held0_nxt      = held0_r;
    held1_nxt      = held1_r;
    clip_seen_nxt  = clip_seen_r;
    res_push       = 1'b0;

    res.frame_kind = (kind_r == ailp_pkg::LK_ACC) ? ailp_pkg::FK_ACC : ailp_pkg::FK_GYRO;
    res.axis_x     = (fidx_r == ailp_pkg::FI_X) ? fv.value : held0_r;
    res.axis_y     = (fidx_r == ailp_pkg::FI_Y) ? fv.value : held1_r;
    res.axis_z     = (fidx_r == ailp_pkg::FI_Z || fidx_r == ailp_pkg::FI_CHK) ?
                     fv.value : '0;
    res.clipped    = clip_seen_r || fv.clip;

    if (go) begin
      if (cls.nl) begin
        // End of line: emit for a known kind, then clear line state
        res_push       = (kind_r != ailp_pkg::LK_NONE);
        line_start_nxt = 1'b1;
        kind_nxt       = ailp_pkg::LK_NONE;
        fidx_nxt       = ailp_pkg::FI_X;
        mag_nxt        = '0;
        neg_nxt        = 1'b0;
        phase_nxt      = ailp_pkg::NP_PRE;
        held0_nxt      = '0;
        held1_nxt      = '0;
        clip_seen_nxt  = 1'b0;
      end else if (line_start_r) begin
        // Latch the kind letter
        line_start_nxt = 1'b0;
        kind_nxt       = cls.gyro ? ailp_pkg::LK_GYRO :
                         cls.acc  ? ailp_pkg::LK_ACC  : ailp_pkg::LK_NONE;
      end else if (fidx_r == ailp_pkg::FI_CHK) begin
        // Drop everything after the check field starts
      end else if (cls.space) begin
        // Close the field; z stays live until newline
        if (fidx_r == ailp_pkg::FI_X || fidx_r == ailp_pkg::FI_Y) begin
          if (fidx_r == ailp_pkg::FI_X) begin
            held0_nxt = fv.value;
          end else begin
            held1_nxt = fv.value;
          end
          clip_seen_nxt = clip_seen_r || fv.clip;
          mag_nxt       = '0;
          neg_nxt       = 1'b0;
          phase_nxt     = ailp_pkg::NP_PRE;
        end
        fidx_nxt = fidx_r + 2'd1;
      end else if (phase_r == ailp_pkg::NP_PRE && cls.ws) begin
        // Skip leading white space
      end else if (phase_r == ailp_pkg::NP_PRE && (cls.plus || cls.minus)) begin
        neg_nxt   = cls.minus;
        phase_nxt = ailp_pkg::NP_SIGN;
      end else if (phase_r != ailp_pkg::NP_DONE && cls.digit) begin
        mag_nxt   = (mag_dec > ailp_pkg::PROD_W'(ailp_pkg::MAG_CAP)) ?
                    ailp_pkg::MAG_CAP : mag_dec[ailp_pkg::MAG_W-1:0];
        phase_nxt = ailp_pkg::NP_DIGITS;
      end else begin
        phase_nxt = ailp_pkg::NP_DONE;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_start_r <= 1'b1;
      kind_r       <= ailp_pkg::LK_NONE;
      fidx_r       <= ailp_pkg::FI_X;
      mag_r        <= '0;
      neg_r        <= 1'b0;
      phase_r      <= ailp_pkg::NP_PRE;
      held0_r      <= '0;
      held1_r      <= '0;
      clip_seen_r  <= 1'b0;
    end else begin
      line_start_r <= line_start_nxt;
      kind_r       <= kind_nxt;
      fidx_r       <= fidx_nxt;
      mag_r        <= mag_nxt;
      neg_r        <= neg_nxt;
      phase_r      <= phase_nxt;
      held0_r      <= held0_nxt;
      held1_r      <= held1_nxt;
      clip_seen_r  <= clip_seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ailp_out_q.sv -----
`default_nettype none

module ailp_out_q (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ailp_pkg::result_t din,
  output      logic              full,
  output      logic              empty,
  input  wire logic              pop,
  output      ailp_pkg::result_t dout
);

  ailp_pkg::result_t q_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the result word
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ascii_imu_line_parser_unit.sv -----
// Channel   Ports                                            Handshake
// input     in_rx_byte                                       in_push / in_full
// result    out_frame_kind, out_axis_x/y/z, out_clipped      out_empty / out_pop
//
// One byte is parsed per cycle unless the result queue is full; a newline byte waits in
// the front queue register, then its result in the result queue register at the ports.
// The front and result queues hold two words each, so either side may stall
// without stopping the other until its queue fills; in_full rises with two words waiting.
// Synchronous active-low reset empties both queues and returns to line start.
`default_nettype none

module ascii_imu_line_parser_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire logic [7:0]                      in_rx_byte,
  output      logic                            in_full,
  output      logic                            out_empty,
  input  wire logic                            out_pop,
  output      logic                            out_frame_kind,
  output      logic signed [ailp_pkg::VALUE_BITS-1:0] out_axis_x,
  output      logic signed [ailp_pkg::VALUE_BITS-1:0] out_axis_y,
  output      logic signed [ailp_pkg::VALUE_BITS-1:0] out_axis_z,
  output      logic                            out_clipped
);

  logic                cls_valid;
  logic                cls_take;
  ailp_pkg::byte_cls_t cls;
  logic                res_full;
  logic                res_push;
  ailp_pkg::result_t   res;
  ailp_pkg::result_t   res_q;

  ailp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .rx_byte   (in_rx_byte),
    .full      (in_full),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_take  (cls_take)
  );

  ailp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_take  (cls_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  ailp_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (res_q)
  );

  assign out_frame_kind = res_q.frame_kind;
  assign out_axis_x     = res_q.axis_x;
  assign out_axis_y     = res_q.axis_y;
  assign out_axis_z     = res_q.axis_z;
  assign out_clipped    = res_q.clipped;

endmodule

`default_nettype wire

// ----- sv/ailp_checker.sv -----
`default_nettype none

module ailp_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_full,
  input wire logic                            out_empty,
  input wire logic                            out_pop,
  input wire logic                            out_frame_kind,
  input wire logic [ailp_pkg::VALUE_BITS-1:0] out_axis_x,
  input wire logic [ailp_pkg::VALUE_BITS-1:0] out_axis_y,
  input wire logic [ailp_pkg::VALUE_BITS-1:0] out_axis_z,
  input wire logic                            out_clipped
);

  // Reset empties the result queue
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset frees the input queue
  a_rst_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  // Hold a waiting result until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_frame_kind) && $stable(out_axis_x) &&
       $stable(out_axis_y) && $stable(out_axis_z) && $stable(out_clipped)))
    else $error("waiting result changed");

  // A clipped result carries at least one saturated value
  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && out_clipped) |->
      (out_axis_x == ailp_pkg::VAL_MAX || out_axis_x == ailp_pkg::VAL_MIN ||
       out_axis_y == ailp_pkg::VAL_MAX || out_axis_y == ailp_pkg::VAL_MIN ||
       out_axis_z == ailp_pkg::VAL_MAX || out_axis_z == ailp_pkg::VAL_MIN))
    else $error("clipped result without a saturated value");

endmodule

bind ascii_imu_line_parser_unit ailp_checker u_ailp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_frame_kind (out_frame_kind),
  .out_axis_x     (out_axis_x),
  .out_axis_y     (out_axis_y),
  .out_axis_z     (out_axis_z),
  .out_clipped    (out_clipped)
);

`default_nettype wire

// ----- bench/tb_ascii_imu_line_parser_unit.sv -----
`default_nettype none

module tb_ascii_imu_line_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    string             text;
    bit                typed;
    ailp_pkg::result_t frame;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic [7:0] in_rx_byte;
  logic in_full;
  logic out_empty;
  logic out_pop;
  logic out_frame_kind;
  logic signed [ailp_pkg::VALUE_BITS-1:0] out_axis_x;
  logic signed [ailp_pkg::VALUE_BITS-1:0] out_axis_y;
  logic signed [ailp_pkg::VALUE_BITS-1:0] out_axis_z;
  logic out_clipped;

  // Parser state mirror
  bit                              pr_line_start;
  ailp_pkg::line_kind_t            pr_kind;
  logic [1:0]                      pr_field;
  logic [ailp_pkg::MAG_W-1:0]      pr_mag;
  logic                            pr_neg;
  ailp_pkg::num_phase_t            pr_phase;
  logic [ailp_pkg::VALUE_BITS-1:0] pr_held [2];
  bit                              pr_clip_seen;

  ailp_pkg::result_t pending_frames[$];
  stim_row_t         stim_rows[$];
  logic [7:0]        line_q[$];
  int                mismatch_cnt = 0;
  bit                sender_fast  = 1'b0;
  bit                drain_fast   = 1'b0;
  bit                hold_req     = 1'b0;

  ascii_imu_line_parser_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_rx_byte    (in_rx_byte),
    .in_full       (in_full),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_frame_kind(out_frame_kind),
    .out_axis_x    (out_axis_x),
    .out_axis_y    (out_axis_y),
    .out_axis_z    (out_axis_z),
    .out_clipped   (out_clipped)
  );

  always #10 clk = ~clk;

  // Clamp a sign/magnitude field into the signed value range
  function automatic void clamp_field(input logic [ailp_pkg::MAG_W-1:0] mag, input logic neg,
                                      output logic [ailp_pkg::VALUE_BITS-1:0] val,
                                      output bit clip);
    if (neg) begin
      clip = (mag > ailp_pkg::HALF_RANGE);
      val  = clip ? ailp_pkg::VAL_MIN : ailp_pkg::VALUE_BITS'(0 - int'(mag));
    end else begin
      clip = (mag >= ailp_pkg::HALF_RANGE);
      val  = clip ? ailp_pkg::VAL_MAX : mag[ailp_pkg::VALUE_BITS-1:0];
    end
  endfunction

  function automatic void clear_number();
    pr_mag   = '0;
    pr_neg   = 1'b0;
    pr_phase = ailp_pkg::NP_PRE;
  endfunction

  function automatic void clear_line();
    pr_line_start = 1'b1;
    pr_kind       = ailp_pkg::LK_NONE;
    pr_field      = ailp_pkg::FI_X;
    pr_held[0]    = '0;
    pr_held[1]    = '0;
    pr_clip_seen  = 1'b0;
    clear_number();
  endfunction

  // Advance the parser mirror by one byte; report a finished frame if any
  task automatic parse_byte(input logic [7:0] b, output bit got,
                            output ailp_pkg::result_t fr);
    logic [ailp_pkg::VALUE_BITS-1:0] v;
    bit          c;
    bit          digit;
    int unsigned nxt;
    got   = 1'b0;
    fr    = '0;
    digit = (b >= ailp_pkg::CH_ZERO) && (b <= ailp_pkg::CH_NINE);
    if (b == ailp_pkg::CH_NL) begin
      if (pr_kind == ailp_pkg::LK_GYRO || pr_kind == ailp_pkg::LK_ACC) begin
        clamp_field(pr_mag, pr_neg, v, c);
        fr.frame_kind = (pr_kind == ailp_pkg::LK_ACC) ? ailp_pkg::FK_ACC : ailp_pkg::FK_GYRO;
        fr.axis_x     = (pr_field == ailp_pkg::FI_X) ? v : pr_held[0];
        fr.axis_y     = (pr_field == ailp_pkg::FI_Y) ? v : pr_held[1];
        fr.axis_z     = (pr_field == ailp_pkg::FI_X || pr_field == ailp_pkg::FI_Y) ? '0 : v;
        fr.clipped    = pr_clip_seen | c;
        got           = 1'b1;
      end
      clear_line();
    end else if (pr_line_start) begin
      pr_line_start = 1'b0;
      pr_kind = (b == ailp_pkg::CH_GYRO) ? ailp_pkg::LK_GYRO :
                (b == ailp_pkg::CH_ACC)  ? ailp_pkg::LK_ACC  : ailp_pkg::LK_NONE;
    end else if (pr_field == ailp_pkg::FI_CHK) begin
      // check field and beyond: drop everything but newline
    end else if (b == ailp_pkg::CH_SPACE) begin
      if (pr_field != ailp_pkg::FI_Z) begin
        clamp_field(pr_mag, pr_neg, v, c);
        pr_held[pr_field[0]] = v;
        if (c) pr_clip_seen = 1'b1;
        clear_number();
      end
      pr_field = pr_field + 2'd1;
    end else if (pr_phase == ailp_pkg::NP_PRE &&
                 (b == ailp_pkg::CH_TAB || b == ailp_pkg::CH_VT ||
                  b == ailp_pkg::CH_FF  || b == ailp_pkg::CH_CR)) begin
      // skip leading white space
    end else if (pr_phase == ailp_pkg::NP_PRE &&
                 (b == ailp_pkg::CH_PLUS || b == ailp_pkg::CH_MINUS)) begin
      pr_neg   = (b == ailp_pkg::CH_MINUS);
      pr_phase = ailp_pkg::NP_SIGN;
    end else if (pr_phase != ailp_pkg::NP_DONE && digit) begin
      nxt      = pr_mag * 10 + (b - ailp_pkg::CH_ZERO);
      pr_mag   = (nxt > ailp_pkg::MAG_CAP) ? ailp_pkg::MAG_CAP : ailp_pkg::MAG_W'(nxt);
      pr_phase = ailp_pkg::NP_DIGITS;
    end else begin
      pr_phase = ailp_pkg::NP_DONE;
    end
  endtask

  // Offer one byte after a random gap (none while sender_fast is set); hold it until the block takes the word
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input ailp_pkg::result_t typed_fr);
    int                gap;
    bit                got;
    ailp_pkg::result_t fr;
    gap = sender_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_byte(b, got, fr);
    if (got) pending_frames.push_back(typed ? typed_fr : fr);
  endtask

  task automatic send_text(input string s, input bit typed, input ailp_pkg::result_t typed_fr);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], typed, typed_fr);
  endtask

  function automatic void add_row(input string s, input bit typed, input ailp_pkg::result_t fr);
    stim_row_t row;
    row.text  = s;
    row.typed = typed;
    row.frame = fr;
    stim_rows.push_back(row);
  endfunction

  // Build one random line: mostly well-formed G/A lines, some noise
  task automatic build_line();
    logic [7:0] ws_set [4];
    int r;
    int nf;
    int nd;
    ws_set = '{ailp_pkg::CH_TAB, ailp_pkg::CH_VT, ailp_pkg::CH_FF, ailp_pkg::CH_CR};
    line_q.delete();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      line_q.push_back(ailp_pkg::CH_GYRO);
    end else if (r < 90) begin
      line_q.push_back(ailp_pkg::CH_ACC);
    end else if (r < 96) begin
      line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_q.push_back(ailp_pkg::CH_NL);
      return;
    end
    nf = $urandom_range(0, 5);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) begin
        line_q.push_back(ailp_pkg::CH_SPACE);
        if ($urandom_range(0, 9) == 0) line_q.push_back(ailp_pkg::CH_SPACE);
      end
      if ($urandom_range(0, 9) == 0) line_q.push_back(ws_set[$urandom_range(0, 3)]);
      r = $urandom_range(0, 99);
      if (r < 30) line_q.push_back(ailp_pkg::CH_MINUS);
      else if (r < 45) line_q.push_back(ailp_pkg::CH_PLUS);
      r  = $urandom_range(0, 99);
      nd = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 5) : $urandom_range(6, 7);
      repeat (nd) line_q.push_back(ailp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) line_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    line_q.push_back(ailp_pkg::CH_NL);
  endtask

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // Compare the popped word with the oldest pending frame
  function automatic void check_frame();
    ailp_pkg::result_t e;
    if (pending_frames.size() == 0) begin
      $display("%0t: word popped with no frame pending: kind %0d x %0d y %0d z %0d clip %0d",
               $time, out_frame_kind, out_axis_x, out_axis_y, out_axis_z, out_clipped);
      mismatch_cnt++;
      return;
    end
    e = pending_frames.pop_front();
    check_field("out_frame_kind", e.frame_kind, out_frame_kind);
    check_field("out_axis_x", $signed(e.axis_x), out_axis_x);
    check_field("out_axis_y", $signed(e.axis_y), out_axis_y);
    check_field("out_axis_z", $signed(e.axis_z), out_axis_z);
    check_field("out_clipped", e.clipped, out_clipped);
  endfunction

  // Result side: random pops, one long hold-off on request
  initial begin : drain
    int gap;
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_pop <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end
      if ($urandom_range(0, 11) == 0) drain_fast = ~drain_fast;
      gap = drain_fast ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      check_frame();
    end
  end

  // Run limit
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("ascii_imu_line_parser_unit verification failed");
    $finish;
  end

  // Input side: directed lines, fill-up phase, then random lines
  initial begin : stim
    int n_sent;
    ailp_pkg::result_t none_fr;
    none_fr    = '0;
    in_push    = 1'b0;
    in_rx_byte = 8'd0;
    rst_n      = 1'b0;
    clear_line();

    add_row("G32767 -32768 0 9\n", 1'b1,
            '{ailp_pkg::FK_GYRO, ailp_pkg::VAL_MAX, ailp_pkg::VAL_MIN, 16'd0, 1'b0});
    add_row("A99999 -99999 40000\n", 1'b1,
            '{ailp_pkg::FK_ACC, ailp_pkg::VAL_MAX, ailp_pkg::VAL_MIN, ailp_pkg::VAL_MAX,
              1'b1});
    add_row("G-32769\n", 1'b1, '{ailp_pkg::FK_GYRO, ailp_pkg::VAL_MIN, 16'd0, 16'd0, 1'b1});
    add_row("\n", 1'b1, none_fr);
    add_row("Q1 2 3\n", 1'b1, none_fr);
    add_row("A12\n", 1'b1, '{ailp_pkg::FK_ACC, 16'd12, 16'd0, 16'd0, 1'b0});
    add_row("A\t+7 x-5 12ab\n", 1'b0, none_fr);
    add_row("G  - 5\n", 1'b0, none_fr);
    add_row("A\015\013\014-3\n", 1'b0, none_fr);
    add_row("G1 2 3 4 -9 \n", 1'b0, none_fr);
    add_row("G\377\200 1\n", 1'b0, none_fr);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) send_text(stim_rows[i].text, stim_rows[i].typed,
                                     stim_rows[i].frame);

    // Fill the queues while the result side holds off
    sender_fast = 1'b1;
    hold_req    = 1'b1;
    repeat (8) begin
      send_text($sformatf("A%0d -%0d %0d\n", $urandom_range(0, 999),
                          $urandom_range(0, 999), $urandom_range(0, 999)), 1'b0, none_fr);
    end
    sender_fast = 1'b0;

    // Pause until every pending frame has drained
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);

    n_sent = 0;
    while (n_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) sender_fast = ~sender_fast;
      build_line();
      foreach (line_q[i]) send_byte(line_q[i], 1'b0, none_fr);
      n_sent += line_q.size();
    end
    @(negedge clk);
    in_push <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ascii_imu_line_parser_unit verification clean");
    end else begin
      $display("ascii_imu_line_parser_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/ailp_pkg.sv
sv/ailp_front.sv
sv/ailp_back.sv
sv/ailp_out_q.sv
sv/ascii_imu_line_parser_unit.sv
sv/ailp_checker.sv
bench/tb_ascii_imu_line_parser_unit.sv
